// File: rtl/core/ste_pkg.sv
// ----------------------------------------------------------------------------
// ste_pkg
// Shared types, constants and fixed-point helpers for the treble exciter.
// ----------------------------------------------------------------------------
`default_nettype none

package ste_pkg;

    localparam int SMP_W    = 24;           // Q1.23 sample
    localparam int MOP_W    = 26;           // multiplier operand, signed
    localparam int PROD_W   = 2 * MOP_W;    // full product
    localparam int ACC_W    = 56;           // biquad accumulator
    localparam int HIST_AW  = 4;            // two stages x two channels x four taps
    localparam int HIST_D   = 1 << HIST_AW;
    localparam int CFG_AW   = 5;            // eight registers at 4-byte stride
    localparam int APB_DW   = 32;
    localparam int TDATA_W  = 2 * SMP_W;

    typedef logic signed [SMP_W-1:0]  sample_t;
    typedef logic signed [MOP_W-1:0]  mop_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef enum logic [2:0] {
        REG_HP1_B0      = 3'd0,
        REG_HP1_A1      = 3'd1,
        REG_HP1_A2      = 3'd2,
        REG_HP2_GAIN    = 3'd3,
        REG_HP2_A1      = 3'd4,
        REG_HP2_A2      = 3'd5,
        REG_SHAPE_COEFF = 3'd6,
        REG_MIX_LEVEL   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic        [22:0] hp1_b0;
        logic signed [23:0] hp1_a1;
        logic signed [23:0] hp1_a2;
        logic        [22:0] hp2_gain;
        logic signed [23:0] hp2_a1;
        logic signed [23:0] hp2_a2;
        logic        [15:0] shape_coeff;
        logic        [15:0] mix_level;
    } cfg_t;

    typedef struct packed {
        logic               we;
        logic [HIST_AW-1:0] addr;
        sample_t            wdata;
    } mem_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_B0,
        ST_A1,
        ST_A2,
        ST_ACC,
        ST_WY,
        ST_CK,
        ST_CT,
        ST_CW,
        ST_CS,
        ST_MX,
        ST_OUT,
        ST_DONE
    } state_t;

    localparam acc_t SAT_HI = acc_t'((2 ** (SMP_W - 1)) - 1);
    localparam acc_t SAT_LO = acc_t'(-(2 ** (SMP_W - 1)));
    localparam acc_t UNITY  = acc_t'(2 ** (SMP_W - 1));

    // round half up, then arithmetic shift
    function automatic acc_t rnd_shift(input acc_t v, input int unsigned sh);
        acc_t half;
        half = acc_t'(1) <<< (sh - 1);
        return (v + half) >>> sh;
    endfunction

    function automatic sample_t sat_smp(input acc_t v);
        sample_t r;
        if (v > SAT_HI) begin
            r = SAT_HI[SMP_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[SMP_W-1:0];
        end else begin
            r = v[SMP_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/stereo_treble_exciter_unit.sv
// ----------------------------------------------------------------------------
// stereo_treble_exciter_unit
// Stereo treble exciter: highpass, soft clip, highpass, mix back onto dry.
// ----------------------------------------------------------------------------
// One beat on the s_ side carries a left/right pair of Q1.23 samples; one
// beat on the m_ side returns the processed pair. Per channel the pair runs a
// biquad highpass (b1 = -2*b0, b2 = b0), a soft clipper x*(1 - k*|x|), a
// second highpass whose b0 carries the drive gain, and then adds the mix-
// scaled wet signal to the dry input with 24-bit saturation. All filter
// history (x[n-1], x[n-2], y[n-1], y[n-2] for both stages and channels) lives
// in one 16-entry single-port RAM, read four entries per stage and written
// back while the shared 26x26 multiplier works through the taps. Per channel
// each stage reads its history from the RAM and then runs its MAC steps; the
// clipper sits between the stages and the mix follows the second one. The
// single RAM port and the one multiplier keep these steps serial. One pair
// is in flight at a time; the next input beat is accepted while the
// previous result still waits on m_tready. The history reads as zero after
// reset with no clearing pass. The user must see that coefficients are
// written over APB only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_treble_exciter_unit
    import ste_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,    // [23:0] left_in, [47:24] right_in

    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [TDATA_W-1:0] m_tdata,    // [23:0] left_out, [47:24] right_out

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [CFG_AW-1:0]  paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    output logic      [APB_DW-1:0]  prdata,
    output logic                    pready
);

    cfg_t     cfg;        // live coefficient set
    mem_req_t mem_req;    // engine -> history RAM
    sample_t  mem_rdata;  // history RAM -> engine, in the cycle after the request

    ste_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ste_hist_mem u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rdata   (mem_rdata)
    );

    // sequencer: read history, MAC the taps, write back, clip, mix, emit
    ste_engine u_eng (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// File: rtl/core/ste_cfg_regs.sv
// ----------------------------------------------------------------------------
// ste_cfg_regs
// APB register file for filter coefficients, shape and mix settings.
// ----------------------------------------------------------------------------
`default_nettype none

module ste_cfg_regs
    import ste_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hp1_b0      <= 23'd4194304;   // 1.0 in Q2.22
            cfg_reg.hp1_a1      <= '0;
            cfg_reg.hp1_a2      <= '0;
            cfg_reg.hp2_gain    <= 23'd2097152;   // 1.0 in Q3.21
            cfg_reg.hp2_a1      <= '0;
            cfg_reg.hp2_a2      <= '0;
            cfg_reg.shape_coeff <= '0;
            cfg_reg.mix_level   <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_HP1_B0:      cfg_reg.hp1_b0      <= pwdata[22:0];
                REG_HP1_A1:      cfg_reg.hp1_a1      <= pwdata[23:0];
                REG_HP1_A2:      cfg_reg.hp1_a2      <= pwdata[23:0];
                REG_HP2_GAIN:    cfg_reg.hp2_gain    <= pwdata[22:0];
                REG_HP2_A1:      cfg_reg.hp2_a1      <= pwdata[23:0];
                REG_HP2_A2:      cfg_reg.hp2_a2      <= pwdata[23:0];
                REG_SHAPE_COEFF: cfg_reg.shape_coeff <= pwdata[15:0];
                REG_MIX_LEVEL:   cfg_reg.mix_level   <= pwdata[15:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // signed coefficients read back sign-extended
    always_comb begin
        unique case (idx)
            REG_HP1_B0:      prdata = {9'd0, cfg_reg.hp1_b0};
            REG_HP1_A1:      prdata = {{8{cfg_reg.hp1_a1[23]}}, cfg_reg.hp1_a1};
            REG_HP1_A2:      prdata = {{8{cfg_reg.hp1_a2[23]}}, cfg_reg.hp1_a2};
            REG_HP2_GAIN:    prdata = {9'd0, cfg_reg.hp2_gain};
            REG_HP2_A1:      prdata = {{8{cfg_reg.hp2_a1[23]}}, cfg_reg.hp2_a1};
            REG_HP2_A2:      prdata = {{8{cfg_reg.hp2_a2[23]}}, cfg_reg.hp2_a2};
            REG_SHAPE_COEFF: prdata = {16'd0, cfg_reg.shape_coeff};
            REG_MIX_LEVEL:   prdata = {16'd0, cfg_reg.mix_level};
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/ste_hist_mem.sv
// ----------------------------------------------------------------------------
// ste_hist_mem
// Single-port filter history RAM, registered read, zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ste_hist_mem
    import ste_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire mem_req_t req,
    output sample_t       rdata
);

    sample_t           ram [HIST_D];
    logic [HIST_D-1:0] vld_reg;
    logic              vld_q_reg;
    sample_t           rd_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            ram[req.addr] <= req.wdata;
        end
        rd_reg <= ram[req.addr];
    end

    // per-entry valid bits stand in for clearing the array
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end else begin
            if (req.we) begin
                vld_reg[req.addr] <= 1'b1;
            end
            vld_q_reg <= vld_reg[req.addr];
        end
    end

    assign rdata = vld_q_reg ? rd_reg : '0;

endmodule

`default_nettype wire

// File: rtl/core/ste_engine.sv
// ----------------------------------------------------------------------------
// ste_engine
// Sequencer and shared multiply-accumulate datapath for both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module ste_engine
    import ste_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cfg_t               cfg,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [TDATA_W-1:0] m_tdata,
    output mem_req_t                mem_req,
    input  wire sample_t            mem_rdata
);

    // history slot offsets inside one channel/stage group
    localparam logic [1:0] OFF_X1 = 2'd0;
    localparam logic [1:0] OFF_X2 = 2'd1;
    localparam logic [1:0] OFF_Y1 = 2'd2;
    localparam logic [1:0] OFF_Y2 = 2'd3;

    state_t  state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic    ch_reg, ch_next;
    logic    stg_reg, stg_next;
    sample_t in_l_reg, in_l_next;
    sample_t in_r_reg, in_r_next;
    sample_t x_reg, x_next;
    sample_t y_reg, y_next;
    sample_t h_reg [4];
    sample_t h_next [4];
    logic signed [24:0] om_reg, om_next;
    prod_t   prod_reg;
    acc_t    acc_reg, acc_next;
    sample_t res_l_reg, res_l_next;
    sample_t res_r_reg, res_r_next;
    logic    m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    mop_t    mul_a, mul_b;
    mop_t    diff;
    mop_t    b0_op, a1_op, a2_op;
    logic signed [24:0] y_ext, mag;
    logic [2:0] cm1;
    acc_t    prod_ext;
    sample_t y_sat, wet_sat, out_sat;
    acc_t    t_val;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // x - 2*x[n-1] + x[n-2]
    assign diff = mop_t'(x_reg) - (mop_t'(h_reg[0]) <<< 1) + mop_t'(h_reg[1]);

    assign b0_op = stg_reg ? mop_t'({1'b0, cfg.hp2_gain}) : mop_t'({1'b0, cfg.hp1_b0});
    assign a1_op = stg_reg ? mop_t'(cfg.hp2_a1) : mop_t'(cfg.hp1_a1);
    assign a2_op = stg_reg ? mop_t'(cfg.hp2_a2) : mop_t'(cfg.hp1_a2);

    assign y_ext    = {y_reg[SMP_W-1], y_reg};
    assign mag      = y_ext[24] ? -y_ext : y_ext;
    assign cm1      = cnt_reg - 3'd1;
    assign prod_ext = acc_t'(prod_reg);

    assign y_sat   = sat_smp(rnd_shift(acc_reg, 22));
    assign t_val   = rnd_shift(prod_ext, 16);
    assign wet_sat = sat_smp(rnd_shift(prod_ext, 23));
    assign out_sat = sat_smp(acc_t'(ch_reg ? in_r_reg : in_l_reg) + rnd_shift(prod_ext, 12));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        ch_reg      <= ch_next;
        stg_reg     <= stg_next;
        in_l_reg    <= in_l_next;
        in_r_reg    <= in_r_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        h_reg       <= h_next;
        om_reg      <= om_next;
        prod_reg    <= mul_a * mul_b;
        acc_reg     <= acc_next;
        res_l_reg   <= res_l_next;
        res_r_reg   <= res_r_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ch_next       = ch_reg;
        stg_next      = stg_reg;
        in_l_next     = in_l_reg;
        in_r_next     = in_r_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        h_next        = h_reg;
        om_next       = om_reg;
        acc_next      = acc_reg;
        res_l_next    = res_l_reg;
        res_r_next    = res_r_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        mul_a         = '0;
        mul_b         = '0;
        mem_req.we    = 1'b0;
        mem_req.addr  = {stg_reg, ch_reg, cnt_reg[1:0]};
        mem_req.wdata = x_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    in_l_next  = s_tdata[SMP_W-1:0];
                    in_r_next  = s_tdata[TDATA_W-1:SMP_W];
                    x_next     = s_tdata[SMP_W-1:0];
                    ch_next    = 1'b0;
                    stg_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                // issue reads 0..3, capture each in the following cycle
                if (cnt_reg != 3'd0) begin
                    h_next[cm1[1:0]] = mem_rdata;
                end
                if (cnt_reg == 3'd4) begin
                    cnt_next   = '0;
                    state_next = ST_B0;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_B0: begin
                mul_a         = b0_op;
                mul_b         = diff;
                mem_req.we    = 1'b1;
                mem_req.addr  = {stg_reg, ch_reg, OFF_X2};
                mem_req.wdata = h_reg[0];
                state_next    = ST_A1;
            end
            ST_A1: begin
                acc_next      = stg_reg ? (prod_ext <<< 1) : prod_ext;
                mul_a         = a1_op;
                mul_b         = mop_t'(h_reg[2]);
                mem_req.we    = 1'b1;
                mem_req.addr  = {stg_reg, ch_reg, OFF_X1};
                mem_req.wdata = x_reg;
                state_next    = ST_A2;
            end
            ST_A2: begin
                acc_next      = acc_reg - prod_ext;
                mul_a         = a2_op;
                mul_b         = mop_t'(h_reg[3]);
                mem_req.we    = 1'b1;
                mem_req.addr  = {stg_reg, ch_reg, OFF_Y2};
                mem_req.wdata = h_reg[2];
                state_next    = ST_ACC;
            end
            ST_ACC: begin
                acc_next   = acc_reg - prod_ext;
                state_next = ST_WY;
            end
            ST_WY: begin
                y_next        = y_sat;
                mem_req.we    = 1'b1;
                mem_req.addr  = {stg_reg, ch_reg, OFF_Y1};
                mem_req.wdata = y_sat;
                state_next    = stg_reg ? ST_MX : ST_CK;
            end
            ST_CK: begin
                mul_a      = mop_t'(mag);
                mul_b      = mop_t'({1'b0, cfg.shape_coeff});
                state_next = ST_CT;
            end
            ST_CT: begin
                om_next    = 25'(UNITY - t_val);
                state_next = ST_CW;
            end
            ST_CW: begin
                mul_a      = mop_t'(y_reg);
                mul_b      = mop_t'(om_reg);
                state_next = ST_CS;
            end
            ST_CS: begin
                x_next     = wet_sat;
                stg_next   = 1'b1;
                cnt_next   = '0;
                state_next = ST_READ;
            end
            ST_MX: begin
                mul_a      = mop_t'(y_reg);
                mul_b      = mop_t'({1'b0, cfg.mix_level});
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!ch_reg) begin
                    res_l_next = out_sat;
                    ch_next    = 1'b1;
                    stg_next   = 1'b0;
                    x_next     = in_r_reg;
                    cnt_next   = '0;
                    state_next = ST_READ;
                end else begin
                    res_r_next = out_sat;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {res_r_reg, res_l_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/ste_checker.sv
// ----------------------------------------------------------------------------
// ste_checker
// Port-level checks on the exciter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ste_checker
    import ste_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic               psel,
    input wire logic               penable,
    input wire logic               pwrite,
    input wire logic [CFG_AW-1:0]  paddr,
    input wire logic [APB_DW-1:0]  pwdata,
    input wire logic [APB_DW-1:0]  prdata,
    input wire logic               pready
);

    // held result does not move under backpressure
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

    // one pair in flight: no back-to-back input beats
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a pair is in work");

    // a fresh result appears only as the engine finishes, never from idle
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $rose(m_tvalid)) |-> $past(!s_tready))
        else $error("result raised without a pair in work");

    // shape register reads back what was written
    a_shape_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $past(psel && penable && pwrite && pready)
         && ($past(paddr[4:2]) == REG_SHAPE_COEFF) && (paddr[4:2] == REG_SHAPE_COEFF))
        |-> (prdata == {16'd0, $past(pwdata[15:0])}))
        else $error("shape register readback mismatch");

endmodule

bind stereo_treble_exciter_unit ste_checker u_ste_checker (.*);

`default_nettype wire

// File: tb/ste_checker.sv
// ----------------------------------------------------------------------------
// ste_exciter_checker
// Passive checker for the treble exciter: tracks coefficient writes on APB,
// predicts each output pair from the input beats, and compares result beats.
// ----------------------------------------------------------------------------
module ste_exciter_checker
    import ste_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,    // [23:0] left_in, [47:24] right_in

    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic [TDATA_W-1:0] m_tdata,    // [23:0] left_out, [47:24] right_out

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic               pready,
    input  wire logic [CFG_AW-1:0]  paddr,
    input  wire logic [APB_DW-1:0]  pwdata,

    output int                      errors,
    output int                      pending
);

    typedef struct packed {
        sample_t right;
        sample_t left;
    } pair_t;

    localparam longint Q23_MAX = 64'sd8388607;
    localparam longint Q23_MIN = -64'sd8388608;

    cfg_t    cfg;
    sample_t hist [2][2][4];        // [stage][channel]: x1, x2, y1, y2
    pair_t   expected_pairs [$];
    int      mismatches = 0;

    function automatic longint round_sh(input longint v, input int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic sample_t clamp24(input longint v);
        if (v > Q23_MAX) return sample_t'(Q23_MAX);
        if (v < Q23_MIN) return sample_t'(Q23_MIN);
        return sample_t'(v);
    endfunction

    // y = b0*(x - 2*x1 + x2) - a1*y1 - a2*y2, history updated in place
    function automatic sample_t highpass(input int stg, input int ch, input sample_t x);
        longint  b, a1, a2, acc;
        sample_t y;
        if (stg == 0) begin
            b  = longint'(cfg.hp1_b0);
            a1 = longint'($signed(cfg.hp1_a1));
            a2 = longint'($signed(cfg.hp1_a2));
        end else begin
            b  = 2 * longint'(cfg.hp2_gain);    // Q3.21 gain lifted to Q2.22
            a1 = longint'($signed(cfg.hp2_a1));
            a2 = longint'($signed(cfg.hp2_a2));
        end
        acc = b * (longint'(x) - 2 * longint'(hist[stg][ch][0]) + longint'(hist[stg][ch][1]))
              - a1 * longint'(hist[stg][ch][2]) - a2 * longint'(hist[stg][ch][3]);
        y = clamp24(round_sh(acc, 22));
        hist[stg][ch][1] = hist[stg][ch][0];
        hist[stg][ch][0] = x;
        hist[stg][ch][3] = hist[stg][ch][2];
        hist[stg][ch][2] = y;
        return y;
    endfunction

    function automatic sample_t excite(input int ch, input sample_t dry);
        sample_t d, w, e;
        longint  mag, t;
        d   = highpass(0, ch, dry);
        mag = (d < 0) ? -longint'(d) : longint'(d);
        t   = round_sh(longint'(cfg.shape_coeff) * mag, 16);
        w   = clamp24(round_sh(longint'(d) * ((64'sd1 <<< 23) - t), 23));
        e   = highpass(1, ch, w);
        return clamp24(longint'(dry) + round_sh(longint'(e) * longint'(cfg.mix_level), 12));
    endfunction

    always @(posedge aclk) begin : monitor
        pair_t got, want;
        if (!aresetn) begin
            cfg             = '0;
            cfg.hp1_b0      = 23'd4194304;
            cfg.hp2_gain    = 23'd2097152;
            for (int s = 0; s < 2; s++)
                for (int c = 0; c < 2; c++)
                    for (int k = 0; k < 4; k++)
                        hist[s][c][k] = '0;
            expected_pairs.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[CFG_AW-1:2]))
                    REG_HP1_B0:      cfg.hp1_b0      = pwdata[22:0];
                    REG_HP1_A1:      cfg.hp1_a1      = pwdata[23:0];
                    REG_HP1_A2:      cfg.hp1_a2      = pwdata[23:0];
                    REG_HP2_GAIN:    cfg.hp2_gain    = pwdata[22:0];
                    REG_HP2_A1:      cfg.hp2_a1      = pwdata[23:0];
                    REG_HP2_A2:      cfg.hp2_a2      = pwdata[23:0];
                    REG_SHAPE_COEFF: cfg.shape_coeff = pwdata[15:0];
                    REG_MIX_LEVEL:   cfg.mix_level   = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                want.left  = excite(0, s_tdata[23:0]);
                want.right = excite(1, s_tdata[47:24]);
                expected_pairs.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_pairs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: left %0d right %0d",
                                 got.left, got.right);
                end else begin
                    want = expected_pairs.pop_front();
                    if (got.left !== want.left) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("left_out mismatch: expected %0d, got %0d",
                                     want.left, got.left);
                    end
                    if (got.right !== want.right) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("right_out mismatch: expected %0d, got %0d",
                                     want.right, got.right);
                    end
                end
            end
        end
        errors  <= mismatches;
        pending <= expected_pairs.size();
    end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the stereo treble exciter.
// ----------------------------------------------------------------------------
// Drives sample pairs on the s_ stream and coefficient writes on APB, with
// random gaps on both stream sides. A side checker predicts every output
// pair and counts mismatches; this module only makes traffic and decides.
// ----------------------------------------------------------------------------
module tb_top;
    import ste_pkg::*;

    localparam int      WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
    localparam int      HOLD_CYCLES    = 600;   // long m_tready hold-off
    localparam int      DRAIN_CYCLES   = 60;    // a bit over one pair's latency
    localparam sample_t S_MAX          = sample_t'(24'h7FFFFF);
    localparam sample_t S_MIN          = sample_t'(24'h800000);

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [CFG_AW-1:0]  paddr    = '0;
    logic [APB_DW-1:0]  pwdata   = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    int   errors, pending;
    int   out_beats   = 0;
    int   quiet_cnt   = 0;
    int   stall_cnt   = 0;
    int   hold_cnt    = 0;
    logic hold_done   = 1'b0;
    logic rx_idle_en  = 1'b0;
    logic tx_idle_en  = 1'b0;

    always #5 aclk = ~aclk;

    stereo_treble_exciter_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ste_exciter_checker chk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .errors   (errors),
        .pending  (pending)
    );

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 4);
        return $urandom_range(12, 70);
    endfunction

    // full-scale noise most of the time, with small signals and rails mixed in
    function automatic sample_t rand_sample();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            case ($urandom_range(0, 4))
                0:       return S_MAX;
                1:       return S_MIN;
                2:       return sample_t'(-1);
                3:       return sample_t'(1);
                default: return '0;
            endcase
        end
        if (roll < 3) return sample_t'(int'($urandom_range(0, 8191)) - 4096);
        return sample_t'($urandom);
    endfunction

    // Register value for a random setting: a whole random word (upper bits
    // beyond the field must be dropped), a field extreme, or a plausible
    // exciter setting.
    function automatic logic [31:0] pick_reg(input reg_idx_t idx);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) return $urandom;
        if (roll < 55) begin
            case (idx)
                REG_HP1_B0, REG_HP2_GAIN:       return $urandom_range(0, 1) ? 32'h7FFFFF : 32'h0;
                REG_SHAPE_COEFF, REG_MIX_LEVEL: return $urandom_range(0, 1) ? 32'hFFFF : 32'h0;
                default:                        return $urandom_range(0, 1) ? 32'h7FFFFF
                                                                            : 32'hFF800000;
            endcase
        end
        case (idx)
            REG_HP1_B0, REG_HP2_GAIN: return $urandom_range(2500000, 3900000);
            REG_HP1_A1, REG_HP2_A1:   return 32'(-int'($urandom_range(5500000, 6700000)));
            REG_HP1_A2, REG_HP2_A2:   return $urandom_range(1900000, 2900000);
            REG_SHAPE_COEFF:          return $urandom_range(0, 49152);
            default:                  return $urandom_range(0, 40960);
        endcase
    endfunction

    // setup cycle, then access cycle; write lands on the access edge
    task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // bus returns to idle before the next transfer
        @(posedge aclk);
    endtask

    task automatic write_config(input logic [31:0] b0, a1, a2, gain, b_a1, b_a2,
                                input logic [31:0] shape, mix);
        apb_write(REG_HP1_B0, b0);
        apb_write(REG_HP1_A1, a1);
        apb_write(REG_HP1_A2, a2);
        apb_write(REG_HP2_GAIN, gain);
        apb_write(REG_HP2_A1, b_a1);
        apb_write(REG_HP2_A2, b_a2);
        apb_write(REG_SHAPE_COEFF, shape);
        apb_write(REG_MIX_LEVEL, mix);
    endtask

    // One pair per call. s_tvalid stays up across back-to-back beats; during
    // a gap it drops and the data lines carry junk.
    task automatic send_pair(input sample_t l, input sample_t r);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= TDATA_W'({$urandom, $urandom});
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, l};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_random(input int n);
        repeat (n) send_pair(rand_sample(), rand_sample());
    endtask

    // stop offering, wait for every predicted pair to come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Receiver: random stalls, plus one long hold-off partway through so the
    // block fills up and has to back-pressure the sender.
    always @(posedge aclk) begin : receiver
        int gap;
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && out_beats >= 120) begin
            hold_done <= 1'b1;
            hold_cnt  <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (stall_cnt != 0) begin
            stall_cnt <= stall_cnt - 1;
            m_tready  <= 1'b0;
        end else begin
            gap = rx_idle_en ? pick_gap() : 0;
            if (gap == 0) begin
                m_tready <= 1'b1;
            end else begin
                stall_cnt <= gap - 1;
                m_tready  <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) out_beats <= out_beats + 1;
    end

    // Watchdog: any beat or register access counts as progress.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cnt <= 0;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
        if (quiet_cnt >= WATCHDOG_LIMIT) begin
            $display("[stereo_treble_exciter_unit] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        // directed pairs: rails, sign flips, Nyquist-rate swing, impulse
        sample_t dir_l [16] = '{'0, S_MAX, S_MIN, S_MAX, S_MIN, sample_t'(-1), sample_t'(1),
                                S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, '0, '0, '0,
                                sample_t'(24'h400000)};
        sample_t dir_r [16] = '{'0, S_MIN, S_MAX, S_MAX, S_MIN, sample_t'(1), sample_t'(-1),
                                S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, '0, '0, '0,
                                sample_t'(24'hC00000)};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset coefficients: b0 and gain at 1.0, no feedback, no shaping, no mix
        tx_idle_en <= 1'b1;
        rx_idle_en <= 1'b1;
        send_random(44);
        drain();

        // a typical exciter setting; the long receiver hold-off falls here
        write_config(32'd3175500, -32'sd6099460, 32'd2407950,
                     32'd3175500, -32'sd6099460, 32'd2407950, 32'd24576, 32'd8192);
        for (int i = 0; i < 16; i++) send_pair(dir_l[i], dir_r[i]);
        send_random(250);
        drain();

        // every coefficient at its top: unstable filters, hard saturation
        write_config(32'h7FFFFF, 32'h7FFFFF, 32'h7FFFFF,
                     32'h7FFFFF, 32'h7FFFFF, 32'h7FFFFF, 32'hFFFF, 32'hFFFF);
        send_random(60);
        drain();

        // max gains against the most negative feedback, shape and mix at range top
        tx_idle_en <= 1'b0;
        rx_idle_en <= 1'b0;
        write_config(32'h7FFFFF, 32'hFF800000, 32'hFF800000,
                     32'h7FFFFF, 32'hFF800000, 32'hFF800000, 32'd49152, 32'd40960);
        send_random(60);
        drain();

        // everything zero: output must equal the dry input
        tx_idle_en <= 1'b1;
        rx_idle_en <= 1'b1;
        write_config('0, '0, '0, '0, '0, '0, '0, '0);
        send_random(30);
        drain();

        // random settings, idling switched on and off between them
        for (int k = 0; k < 6; k++) begin
            tx_idle_en <= (k % 3) != 2;
            rx_idle_en <= (k % 2) == 0;
            write_config(pick_reg(REG_HP1_B0), pick_reg(REG_HP1_A1), pick_reg(REG_HP1_A2),
                         pick_reg(REG_HP2_GAIN), pick_reg(REG_HP2_A1), pick_reg(REG_HP2_A2),
                         pick_reg(REG_SHAPE_COEFF), pick_reg(REG_MIX_LEVEL));
            send_random(65);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("[stereo_treble_exciter_unit] OK");
        end else begin
            $display("[stereo_treble_exciter_unit] ERROR");
        end
        $finish;
    end

endmodule
